@@ hw/rtl/cdcs_pkg.sv @@
// Shared types, command codes and the sigmoid table for the causal depthwise convolution step.
package cdcs_pkg;

    typedef logic [1:0]         cmd_t;
    typedef logic signed [15:0] word_t;
    typedef logic               cfg_idx_t;

    localparam cmd_t CMD_SAMPLE = 2'd0;
    localparam cmd_t CMD_WEIGHT = 2'd1;
    localparam cmd_t CMD_BIAS   = 2'd2;

    localparam cfg_idx_t CFG_SILU = 1'b0;
    localparam cfg_idx_t CFG_BIAS = 1'b1;

    localparam int SIG_ENTRIES = 17;

    localparam logic [15:0] SIG_TAB [SIG_ENTRIES] = '{
        16'd16384, 16'd20397, 16'd23955, 16'd26790, 16'd28862, 16'd30282,
        16'd31214, 16'd31808, 16'd32179, 16'd32408, 16'd32549, 16'd32635,
        16'd32687, 16'd32719, 16'd32738, 16'd32750, 16'd32757
    };

endpackage

@@ hw/rtl/causal_depthwise_conv_step.sv @@
// Causal depthwise convolution step: per-slot history memory, coefficient memories and datapath.
// A sample transfer reads the slot history, tap weights and channel bias from registered-read
// memories, multiplies all taps in parallel, sums (with the bias if enabled) and rounds, looks
// up and interpolates the sigmoid, and applies SiLU if enabled before saturating. The input is
// ready again as the result enters the output register, and no new sample is taken before then;
// the stages are the read, the multiply with the history row write-back, the sum, the sigmoid
// and the output stage with SiLU, and a result still waiting in the output register holds the
// next one in the output stage. Weight writes, bias writes, null slots and ignored commands are
// taken without leaving the idle state. After reset the block clears the history memory one row
// per cycle, all SLOTS*CHANNELS rows (1024 at the default sizes), with s_ready low; configuration
// writes are taken throughout.
module causal_depthwise_conv_step #(
    parameter int SLOTS    = 16,
    parameter int CHANNELS = 64,
    parameter int TAPS     = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cdcs_pkg::cfg_idx_t    cfg_index,
    input  logic                  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cdcs_pkg::cmd_t        s_command,
    input  logic                  s_slot_valid,
    input  logic [3:0]            s_slot,
    input  logic [5:0]            s_channel,
    input  logic [1:0]            s_tap,
    input  cdcs_pkg::word_t       s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_slot_out,
    output logic [5:0]            m_channel_out,
    output cdcs_pkg::word_t       m_filtered
);
    import cdcs_pkg::*;

    localparam int HL         = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int HIST_DEPTH = SLOTS * CHANNELS;
    localparam int HA_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SL_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TP_W       = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W      = 32 + $clog2(TAPS + 1) + 1;
    localparam int PRE_W      = ACC_W - 14;
    localparam int SW         = PRE_W + 18;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_SIG   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // Memories.
    logic [HL-1:0][15:0] hist_mem [HIST_DEPTH];
    word_t               wt_mem   [CHANNELS][TAPS];
    word_t               bias_mem [CHANNELS];

    logic [HL-1:0][15:0] hist_rd_reg;
    word_t               wt_rd_reg [TAPS];
    word_t               bias_rd_reg;

    // Control.
    logic [2:0]      state_reg, state_next;
    logic [HA_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic            silu_en_reg, bias_en_reg;
    logic            m_valid_reg, m_valid_next;

    // Item held while it is worked on.
    logic [HA_W-1:0] hist_addr_reg;
    logic [3:0]      slot_reg;
    logic [5:0]      chan_reg;
    word_t           sample_reg;

    // Datapath.
    logic signed [31:0]      prod_next [TAPS];
    logic signed [31:0]      prod_reg  [TAPS];
    logic signed [PRE_W-1:0] pre_next, pre_reg;
    logic [16:0]             sig_next, sig_reg;
    word_t                   filt_next;
    logic [3:0]              m_slot_reg;
    logic [5:0]              m_chan_reg;
    word_t                   m_filt_reg;

    logic            accept, run, wt_we, bias_we, slot_ok, ch_ok, tap_ok, out_load;
    logic [CH_W-1:0] ch_idx;
    logic [SL_W-1:0] sl_idx;
    logic [TP_W-1:0] tp_idx;
    logic [HA_W-1:0] hist_raddr, hist_waddr;
    logic            hist_we;
    logic [HL-1:0][15:0] hist_wdata, hist_shift;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign ch_idx  = CH_W'(s_channel);
    assign sl_idx  = SL_W'(s_slot);
    assign tp_idx  = TP_W'(s_tap);
    assign slot_ok = 32'(s_slot) < 32'(SLOTS);
    assign ch_ok   = 32'(s_channel) < 32'(CHANNELS);
    assign tap_ok  = 32'(s_tap) < 32'(TAPS);
    assign hist_raddr = HA_W'(32'(sl_idx) * 32'(CHANNELS) + 32'(ch_idx));

    always_comb begin
        run     = 1'b0;
        wt_we   = 1'b0;
        bias_we = 1'b0;
        case (s_command)
            CMD_SAMPLE: run     = accept && s_slot_valid && slot_ok && ch_ok;
            CMD_WEIGHT: wt_we   = accept && ch_ok && tap_ok;
            CMD_BIAS:   bias_we = accept && ch_ok;
            default: ;
        endcase
    end

    // The new raw sample enters at the young end of the row and the oldest entry drops out.
    always_comb begin
        for (int j = 0; j < HL; j++) begin
            if (j < HL - 1) begin
                hist_shift[j] = hist_rd_reg[(j + 1) % HL];
            end else begin
                hist_shift[j] = sample_reg;
            end
        end
    end

    assign hist_we    = (state_reg == ST_CLEAR) || (state_reg == ST_MUL);
    assign hist_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : hist_addr_reg;
    assign hist_wdata = (state_reg == ST_CLEAR) ? '0 : hist_shift;

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (run) begin
            hist_rd_reg <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_mem[ch_idx][tp_idx] <= s_value;
        end
        if (run) begin
            wt_rd_reg <= wt_mem[ch_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (bias_we) begin
            bias_mem[ch_idx] <= s_value;
        end
        if (run) begin
            bias_rd_reg <= bias_mem[ch_idx];
        end
    end

    // One product per tap; the newest tap takes the incoming sample.
    for (genvar j = 0; j < TAPS; j++) begin : g_prod
        if (j < TAPS - 1) begin : g_hist
            assign prod_next[j] = wt_rd_reg[j] * $signed(hist_rd_reg[j]);
        end else begin : g_new
            assign prod_next[j] = wt_rd_reg[j] * sample_reg;
        end
    end

    // Sum in Q.26 and round half up to Q.12.
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] acc_rnd;
        acc = bias_en_reg ? (ACC_W'(bias_rd_reg) <<< 14) : '0;
        for (int j = 0; j < TAPS; j++) begin
            acc = acc + ACC_W'(prod_reg[j]);
        end
        acc_rnd  = acc + ACC_W'(8192);
        pre_next = PRE_W'(acc_rnd >>> 14);
    end

    // Sigmoid in Q1.15 by linear interpolation between table points half a unit apart.
    always_comb begin
        logic [PRE_W-1:0] pre_abs;
        logic             big;
        logic [3:0]       seg;
        logic [10:0]      frac;
        logic [12:0]      sig_diff;
        logic [23:0]      interp;
        logic [12:0]      step;
        logic [16:0]      s_abs;
        pre_abs  = pre_reg[PRE_W-1] ? PRE_W'(-pre_reg) : PRE_W'(pre_reg);
        big      = |pre_abs[PRE_W-1:15];
        seg      = pre_abs[14:11];
        frac     = pre_abs[10:0];
        sig_diff = 13'(SIG_TAB[5'(seg) + 5'd1] - SIG_TAB[5'(seg)]);
        interp   = 24'(sig_diff) * 24'(frac);
        step     = 13'((interp + 24'd1024) >> 11);
        s_abs    = big ? 17'd32768 : 17'(SIG_TAB[5'(seg)]) + 17'(step);
        sig_next = pre_reg[PRE_W-1] ? 17'd32768 - s_abs : s_abs;
    end

    // SiLU if enabled, then saturation to Q4.12.
    always_comb begin
        logic signed [SW-1:0] silu_prod;
        logic signed [SW-1:0] silu_y;
        logic signed [SW-1:0] sel;
        silu_prod = pre_reg * $signed({1'b0, sig_reg});
        silu_y    = (silu_prod + SW'(16384)) >>> 15;
        sel       = silu_en_reg ? silu_y : SW'(pre_reg);
        if (sel > SW'(32767)) begin
            filt_next = 16'sh7fff;
        end else if (sel < SW'(-32768)) begin
            filt_next = 16'sh8000;
        end else begin
            filt_next = 16'(sel);
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == 32'(HIST_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (run) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_SUM;
            ST_SUM: state_next = ST_SIG;
            ST_SIG: state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            silu_en_reg <= 1'b0;
            bias_en_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SILU: silu_en_reg <= cfg_data;
                    CFG_BIAS: bias_en_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            hist_addr_reg <= hist_raddr;
            slot_reg      <= s_slot;
            chan_reg      <= s_channel;
            sample_reg    <= s_value;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_SUM) begin
            pre_reg <= pre_next;
        end
        if (state_reg == ST_SIG) begin
            sig_reg <= sig_next;
        end
        if (out_load) begin
            m_slot_reg <= slot_reg;
            m_chan_reg <= chan_reg;
            m_filt_reg <= filt_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_slot_out    = m_slot_reg;
    assign m_channel_out = m_chan_reg;
    assign m_filtered    = m_filt_reg;

    // The clearing pass always follows reset.
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (state_reg == ST_CLEAR))
        else $error("history clearing pass did not start after reset");

    // The history write-back only follows a sample that was accepted in the previous cycle.
    a_mul_from_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> $past(run))
        else $error("multiply stage entered without an accepted sample");

    // An accepted sample reaches the output stage through the multiply, sum and sigmoid stages.
    a_sample_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        run |-> ##4 (state_reg == ST_OUT))
        else $error("sample did not reach the output stage in time");

    // A finished result waits while the previous one has not been transferred.
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("result left the output stage while the output register was full");

endmodule

@@ tb/causal_depthwise_conv_step_check.sv @@
// Checker for the causal depthwise convolution step: watches both channels, predicts and compares.
module causal_depthwise_conv_step_check (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cdcs_pkg::cfg_idx_t    cfg_index,
    input  logic                  cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  cdcs_pkg::cmd_t        s_command,
    input  logic                  s_slot_valid,
    input  logic [3:0]            s_slot,
    input  logic [5:0]            s_channel,
    input  logic [1:0]            s_tap,
    input  cdcs_pkg::word_t       s_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [3:0]            m_slot_out,
    input  logic [5:0]            m_channel_out,
    input  cdcs_pkg::word_t       m_filtered,
    output int                    failures,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS    = 16;
    localparam int N_CHANNELS = 64;
    localparam int N_TAPS     = 4;
    localparam int HIST_LEN   = N_TAPS - 1;

    localparam longint SIGMOID_Q15 [17] = '{
        16384, 20397, 23955, 26790, 28862, 30282, 31214, 31808, 32179,
        32408, 32549, 32635, 32687, 32719, 32738, 32750, 32757
    };

    typedef struct packed {
        logic [3:0]         slot;
        logic [5:0]         channel;
        logic signed [15:0] filtered;
    } conv_result_t;

    logic signed [15:0] slot_hist [N_SLOTS][N_CHANNELS][HIST_LEN];
    logic signed [15:0] tap_coef  [N_CHANNELS][N_TAPS];
    logic signed [15:0] chan_bias [N_CHANNELS];
    logic               silu_on;
    logic               bias_on;
    conv_result_t       expected_q [$];

    initial begin
        failures    = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        if (failures < 100) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        failures++;
    endtask

    function automatic logic signed [15:0] filter_sample(input logic [3:0] sl,
                                                         input logic [5:0] ch,
                                                         input logic signed [15:0] x);
        longint acc, pre, res, mag, seg, s;
        acc = bias_on ? longint'(chan_bias[ch]) * 16384 : 0;
        for (int j = 0; j < HIST_LEN; j++) begin
            acc += longint'(tap_coef[ch][j]) * longint'(slot_hist[sl][ch][j]);
        end
        acc += longint'(tap_coef[ch][HIST_LEN]) * longint'(x);
        pre = (acc + 8192) >>> 14;
        res = pre;
        if (silu_on) begin
            mag = (pre < 0) ? -pre : pre;
            if (mag >= 32768) begin
                s = 32768;
            end else begin
                seg = mag >>> 11;
                s = SIGMOID_Q15[seg] + (((SIGMOID_Q15[seg + 1] - SIGMOID_Q15[seg])
                    * (mag & 2047) + 1024) >>> 11);
            end
            if (pre < 0) begin
                s = 32768 - s;
            end
            res = (pre * s + 16384) >>> 15;
        end
        if (res > 32767) begin
            res = 32767;
        end else if (res < -32768) begin
            res = -32768;
        end
        return res[15:0];
    endfunction

    always @(posedge aclk) begin
        conv_result_t head;
        if (!aresetn) begin
            silu_on = 1'b0;
            bias_on = 1'b0;
            expected_q.delete();
            for (int a = 0; a < N_SLOTS; a++) begin
                for (int c = 0; c < N_CHANNELS; c++) begin
                    for (int j = 0; j < HIST_LEN; j++) begin
                        slot_hist[a][c][j] = '0;
                    end
                end
            end
            for (int c = 0; c < N_CHANNELS; c++) begin
                chan_bias[c] = '0;
                for (int t = 0; t < N_TAPS; t++) begin
                    tap_coef[c][t] = '0;
                end
            end
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected, filtered",
                                    m_filtered, 0);
                end else begin
                    head = expected_q.pop_front();
                    if (m_slot_out !== head.slot) begin
                        report_mismatch("slot_out", m_slot_out, head.slot);
                    end
                    if (m_channel_out !== head.channel) begin
                        report_mismatch("channel_out", m_channel_out, head.channel);
                    end
                    if (m_filtered !== head.filtered) begin
                        report_mismatch("filtered", m_filtered, head.filtered);
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == cdcs_pkg::CFG_SILU) begin
                    silu_on = cfg_data;
                end else begin
                    bias_on = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                case (s_command)
                    cdcs_pkg::CMD_WEIGHT: begin
                        tap_coef[s_channel][s_tap] = s_value;
                    end
                    cdcs_pkg::CMD_BIAS: begin
                        chan_bias[s_channel] = s_value;
                    end
                    cdcs_pkg::CMD_SAMPLE: begin
                        if (s_slot_valid) begin
                            head.slot     = s_slot;
                            head.channel  = s_channel;
                            head.filtered = filter_sample(s_slot, s_channel, s_value);
                            expected_q.push_back(head);
                            for (int j = 0; j + 1 < HIST_LEN; j++) begin
                                slot_hist[s_slot][s_channel][j] = slot_hist[s_slot][s_channel][j + 1];
                            end
                            slot_hist[s_slot][s_channel][HIST_LEN - 1] = s_value;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        outstanding = expected_q.size();
    end

endmodule

@@ tb/causal_depthwise_conv_step_test.sv @@
// Top of the testbench for the causal depthwise convolution step: clock, reset, stimulus and verdict.
module causal_depthwise_conv_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam cdcs_pkg::cmd_t CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_QUOTA  = 850;
    localparam int PHASES      = 6;
    // Per phase {silu_enable, bias_enable}, first phase in the lowest bits.
    localparam logic [2*PHASES-1:0] PHASE_CFG = 12'b00_11_01_10_11_00;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    cdcs_pkg::cfg_idx_t    cfg_index;
    logic                  cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    cdcs_pkg::cmd_t        s_command;
    logic                  s_slot_valid;
    logic [3:0]            s_slot;
    logic [5:0]            s_channel;
    logic [1:0]            s_tap;
    cdcs_pkg::word_t       s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [3:0]            m_slot_out;
    logic [5:0]            m_channel_out;
    cdcs_pkg::word_t       m_filtered;

    int   failures;
    int   outstanding;
    int   cycles;
    int   counted;
    bit   tight;
    bit   bias_now;
    bit   [3:0] weights_loaded [64];
    bit   bias_loaded [64];
    logic [3:0] hot_slot [4];
    logic [5:0] hot_ch [4];

    causal_depthwise_conv_step u_top (.*);

    causal_depthwise_conv_step_check u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = tight ? 0 : $urandom_range(0, 19);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic cdcs_pkg::word_t rand_sample_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return cdcs_pkg::word_t'($urandom_range(0, 65535));
        end
        if (r < 22) begin
            case ($urandom_range(0, 3))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return cdcs_pkg::word_t'(int'($urandom_range(0, 12288)) - 6144);
    endfunction

    function automatic cdcs_pkg::word_t rand_weight_word();
        if ($urandom_range(0, 99) < 20) begin
            return cdcs_pkg::word_t'($urandom_range(0, 65535));
        end
        return cdcs_pkg::word_t'(int'($urandom_range(0, 18000)) - 9000);
    endfunction

    task automatic push_item(input cdcs_pkg::cmd_t cmd, input logic sv, input logic [3:0] sl,
                             input logic [5:0] ch, input logic [1:0] tp,
                             input cdcs_pkg::word_t val);
        int gap;
        gap = tight ? 0 : $urandom_range(0, 19);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_slot_valid <= sv;
        s_slot       <= sl;
        s_channel    <= ch;
        s_tap        <= tp;
        s_value      <= val;
        do @(posedge aclk); while (!s_ready);
        if (cmd == cdcs_pkg::CMD_WEIGHT) begin
            weights_loaded[ch][tp] = 1'b1;
        end else if (cmd == cdcs_pkg::CMD_BIAS) begin
            bias_loaded[ch] = 1'b1;
        end
        if (cmd == cdcs_pkg::CMD_WEIGHT || cmd == cdcs_pkg::CMD_BIAS
            || (cmd == cdcs_pkg::CMD_SAMPLE && sv)) begin
            counted++;
        end
    endtask

    // A sample may only read coefficients that have been loaded since reset.
    task automatic send_sample(input logic [3:0] sl, input logic [5:0] ch,
                               input cdcs_pkg::word_t val);
        for (int t = 0; t < 4; t++) begin
            if (!weights_loaded[ch][t]) begin
                push_item(cdcs_pkg::CMD_WEIGHT, 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)), ch, 2'(t), rand_weight_word());
            end
        end
        if (bias_now && !bias_loaded[ch]) begin
            push_item(cdcs_pkg::CMD_BIAS, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      ch, 2'($urandom_range(0, 3)), rand_sample_word());
        end
        push_item(cdcs_pkg::CMD_SAMPLE, 1'b1, sl, ch, 2'($urandom_range(0, 3)), val);
    endtask

    task automatic write_regs(input logic silu, input logic bias);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= cdcs_pkg::CFG_SILU;
        cfg_data  <= silu;
        @(negedge aclk);
        cfg_index <= cdcs_pkg::CFG_BIAS;
        cfg_data  <= bias;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        bias_now = bias;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    initial begin
        int quota_end;
        int pick;
        int k;
        int run;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = cdcs_pkg::CFG_SILU;
        cfg_data     = 1'b0;
        s_valid      = 1'b0;
        s_command    = cdcs_pkg::CMD_SAMPLE;
        s_slot_valid = 1'b0;
        s_slot       = '0;
        s_channel    = '0;
        s_tap        = '0;
        s_value      = '0;
        tight        = 1'b0;
        bias_now     = 1'b0;
        counted      = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_regs(1'b0, 1'b0);
        push_item(cdcs_pkg::CMD_WEIGHT, 1'b0, 4'd15, 6'd0, 2'd0, 16'sh7FFF);
        push_item(cdcs_pkg::CMD_WEIGHT, 1'b1, 4'd0, 6'd0, 2'd1, 16'sh8000);
        push_item(cdcs_pkg::CMD_WEIGHT, 1'b0, 4'd7, 6'd0, 2'd2, 16'sh0001);
        push_item(cdcs_pkg::CMD_WEIGHT, 1'b1, 4'd15, 6'd0, 2'd3, 16'sh4000);
        push_item(cdcs_pkg::CMD_BIAS, 1'b1, 4'd15, 6'd63, 2'd3, 16'sh8000);
        push_item(cdcs_pkg::CMD_BIAS, 1'b0, 4'd0, 6'd0, 2'd0, 16'sh7FFF);
        send_sample(4'd0, 6'd0, 16'sh7FFF);
        send_sample(4'd0, 6'd0, 16'sh8000);
        send_sample(4'd0, 6'd0, 16'sh0000);
        send_sample(4'd0, 6'd0, 16'sh1000);
        send_sample(4'd0, 6'd0, 16'shFFFF);
        push_item(cdcs_pkg::CMD_SAMPLE, 1'b0, 4'd0, 6'd0, 2'd3, 16'sh7FFF);
        push_item(CMD_UNUSED, 1'b1, 4'd15, 6'd63, 2'd3, 16'sh7FFF);
        for (int t = 0; t < 4; t++) begin
            push_item(cdcs_pkg::CMD_WEIGHT, 1'b1, 4'd15, 6'd63, 2'(t), 16'sh8000);
        end
        send_sample(4'd15, 6'd63, 16'sh7FFF);
        send_sample(4'd15, 6'd63, 16'sh7FFF);
        send_sample(4'd15, 6'd63, 16'sh8000);
        settle();
        write_regs(1'b1, 1'b1);
        send_sample(4'd1, 6'd0, 16'sh7FFF);
        send_sample(4'd1, 6'd0, 16'sh8000);
        send_sample(4'd1, 6'd0, 16'sh0800);
        send_sample(4'd15, 6'd63, 16'sh8000);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_regs(PHASE_CFG[2*ph+1], PHASE_CFG[2*ph]);
            for (int h = 0; h < 4; h++) begin
                hot_slot[h] = 4'($urandom_range(0, 15));
                hot_ch[h]   = 6'($urandom_range(0, 63));
            end
            quota_end = counted + ITEM_QUOTA / PHASES;
            while (counted < quota_end) begin
                if ($urandom_range(0, 19) == 0) begin
                    tight = !tight;
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    k   = $urandom_range(0, 3);
                    run = $urandom_range(1, 6);
                    repeat (run) send_sample(hot_slot[k], hot_ch[k], rand_sample_word());
                end else if (pick < 72) begin
                    send_sample(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                                rand_sample_word());
                end else if (pick < 82) begin
                    push_item(cdcs_pkg::CMD_WEIGHT, 1'($urandom_range(0, 1)),
                              4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                              2'($urandom_range(0, 3)), rand_weight_word());
                end else if (pick < 88) begin
                    push_item(cdcs_pkg::CMD_BIAS, 1'($urandom_range(0, 1)),
                              4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                              2'($urandom_range(0, 3)), rand_sample_word());
                end else if (pick < 94) begin
                    push_item(cdcs_pkg::CMD_SAMPLE, 1'b0, 4'($urandom_range(0, 15)),
                              6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                              rand_sample_word());
                end else begin
                    push_item(CMD_UNUSED, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                              rand_sample_word());
                end
            end
        end
        settle();

        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cdcs_pkg.sv
hw/rtl/causal_depthwise_conv_step.sv
tb/causal_depthwise_conv_step_check.sv
tb/causal_depthwise_conv_step_test.sv
